>>> hw/rtl/apint_pkg.sv
package apint_pkg;

  localparam int ITERS     = 30;
  localparam int DIV_STEPS = 58;
  localparam int CNT_W     = 6;

  localparam logic [15:0] WB_RESET = 16'd1638;
  localparam logic [15:0] TS_RESET = 16'd6554;

  localparam logic [35:0] KGAIN      = 36'd652032874;
  localparam logic [32:0] RAD_TO_ANG = 33'd42722830;

  localparam logic [1:0] CFG_WHEEL_BASE = 2'd0;
  localparam logic [1:0] CFG_TIME_STEP  = 2'd1;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_MUL, OP_SAVE_VDT, OP_VEC_INIT, OP_VEC_STEP, OP_VEC_DONE,
    OP_ROT_INIT, OP_ROT_STEP, OP_ROT_DONE, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_DONE,
    OP_ACC_X, OP_ACC_Y, OP_YAW
  } op_t;

  typedef enum logic [2:0] {
    MS_WL, MS_VDT, MS_VC0, MS_VS0, MS_LCS, MS_VRAD, MS_RDS, MS_RDC
  } msel_t;

  typedef enum logic [1:0] {
    SRC_YAW, SRC_STEER, SRC_NEW
  } src_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_WL, S_VEC_INIT, S_VEC, S_VEC_DONE, S_MUL_VDT, S_SAVE_VDT,
    S_ROT_INIT, S_ROT, S_ROT_DONE, S_MUL_LCS, S_DIV_INIT, S_DIV, S_DIV_DONE,
    S_MUL_VRAD, S_STR_MX, S_STR_AX, S_STR_MY, S_STR_AY, S_ARC_MX, S_ARC_AX,
    S_ARC_MY, S_ARC_AY, S_YAW, S_OUT
  } state_t;

  typedef struct packed {
    op_t              op;
    msel_t            msel;
    src_t             src;
    logic             arc;
    logic             emit;
    logic [CNT_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic straight;
    logic sn_zero;
    logic r_zero;
  } stat_t;

  function automatic logic [31:0] atan_f(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;
      5'd29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

>>> hw/rtl/ackermann_pose_integrator_core.sv
// A straight move skips the steering rotation and both divisions; an arc ends early after the
// steering rotation (zero steering sine) or the first division (zero radius). The cost is set
// by the shared CORDIC unit (30 iterations, one vectoring and up to three rotation passes) and
// the shared 58-step restoring divider (up to two passes on an arc).
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous): pose cleared, wheel base 0.4 m, time step 0.1 s.
module ackermann_pose_integrator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // lin_speed [15:0], yaw_rate [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // pos_x [31:0], pos_y [63:32], heading [79:64],
                                  // steer_angle [95:80]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  apint_pkg::cmd_t  cmd;
  apint_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  apint_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  apint_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without a request in progress");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result overwritten before it was taken");

endmodule

>>> hw/rtl/apint_ctrl.sv
module apint_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  apint_pkg::stat_t    stat,
  output apint_pkg::cmd_t     cmd
);

  apint_pkg::state_t            state_r, state_nxt;
  apint_pkg::src_t              ph_r, ph_nxt;
  logic [apint_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         slot_free;
  logic                         rot_last, div_last;

  assign slot_free = !out_valid_r || out_tready;
  assign rot_last  = cnt_r == apint_pkg::CNT_W'(apint_pkg::ITERS - 1);
  assign div_last  = cnt_r == apint_pkg::CNT_W'(apint_pkg::DIV_STEPS - 1);
  assign in_tready  = state_r == apint_pkg::S_IDLE;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apint_pkg::S_IDLE;
      ph_r        <= apint_pkg::SRC_YAW;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r + 1'b1;
    unique case (state_r)
      apint_pkg::S_IDLE:     if (in_tvalid) state_nxt = apint_pkg::S_MUL_WL;
      apint_pkg::S_MUL_WL:   state_nxt = apint_pkg::S_VEC_INIT;
      apint_pkg::S_VEC_INIT: begin
        state_nxt = apint_pkg::S_VEC;
        cnt_nxt   = '0;
      end
      apint_pkg::S_VEC:      if (rot_last) state_nxt = apint_pkg::S_VEC_DONE;
      apint_pkg::S_VEC_DONE: state_nxt = apint_pkg::S_MUL_VDT;
      apint_pkg::S_MUL_VDT:  state_nxt = apint_pkg::S_SAVE_VDT;
      apint_pkg::S_SAVE_VDT: begin
        state_nxt = apint_pkg::S_ROT_INIT;
        ph_nxt    = apint_pkg::SRC_YAW;
      end
      apint_pkg::S_ROT_INIT: begin
        state_nxt = apint_pkg::S_ROT;
        cnt_nxt   = '0;
      end
      apint_pkg::S_ROT:      if (rot_last) state_nxt = apint_pkg::S_ROT_DONE;
      apint_pkg::S_ROT_DONE: begin
        unique case (ph_r)
          apint_pkg::SRC_YAW: begin
            if (stat.straight) begin
              state_nxt = apint_pkg::S_STR_MX;
            end else begin
              state_nxt = apint_pkg::S_ROT_INIT;
              ph_nxt    = apint_pkg::SRC_STEER;
            end
          end
          apint_pkg::SRC_STEER: state_nxt = apint_pkg::S_MUL_LCS;
          default:              state_nxt = apint_pkg::S_ARC_MX;
        endcase
      end
      apint_pkg::S_MUL_LCS:
        state_nxt = stat.sn_zero ? apint_pkg::S_OUT : apint_pkg::S_DIV_INIT;
      apint_pkg::S_DIV_INIT: begin
        state_nxt = apint_pkg::S_DIV;
        cnt_nxt   = '0;
      end
      apint_pkg::S_DIV:      if (div_last) state_nxt = apint_pkg::S_DIV_DONE;
      apint_pkg::S_DIV_DONE: begin
        if (ph_r == apint_pkg::SRC_STEER) begin
          state_nxt = apint_pkg::S_MUL_VRAD;
        end else begin
          state_nxt = apint_pkg::S_ROT_INIT;
        end
      end
      apint_pkg::S_MUL_VRAD: begin
        if (stat.r_zero) begin
          state_nxt = apint_pkg::S_OUT;
        end else begin
          state_nxt = apint_pkg::S_DIV_INIT;
          ph_nxt    = apint_pkg::SRC_NEW;
        end
      end
      apint_pkg::S_STR_MX:   state_nxt = apint_pkg::S_STR_AX;
      apint_pkg::S_STR_AX:   state_nxt = apint_pkg::S_STR_MY;
      apint_pkg::S_STR_MY:   state_nxt = apint_pkg::S_STR_AY;
      apint_pkg::S_STR_AY:   state_nxt = apint_pkg::S_OUT;
      apint_pkg::S_ARC_MX:   state_nxt = apint_pkg::S_ARC_AX;
      apint_pkg::S_ARC_AX:   state_nxt = apint_pkg::S_ARC_MY;
      apint_pkg::S_ARC_MY:   state_nxt = apint_pkg::S_ARC_AY;
      apint_pkg::S_ARC_AY:   state_nxt = apint_pkg::S_YAW;
      apint_pkg::S_YAW:      state_nxt = apint_pkg::S_OUT;
      apint_pkg::S_OUT:      if (slot_free) state_nxt = apint_pkg::S_IDLE;
      default:               state_nxt = apint_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = apint_pkg::OP_IDLE;
    cmd.msel      = apint_pkg::MS_WL;
    cmd.src       = ph_r;
    cmd.iter      = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      apint_pkg::S_IDLE:     if (in_tvalid) cmd.op = apint_pkg::OP_LOAD;
      apint_pkg::S_MUL_WL:   cmd.op = apint_pkg::OP_MUL;
      apint_pkg::S_VEC_INIT: cmd.op = apint_pkg::OP_VEC_INIT;
      apint_pkg::S_VEC:      cmd.op = apint_pkg::OP_VEC_STEP;
      apint_pkg::S_VEC_DONE: cmd.op = apint_pkg::OP_VEC_DONE;
      apint_pkg::S_MUL_VDT: begin
        cmd.op   = apint_pkg::OP_MUL;
        cmd.msel = apint_pkg::MS_VDT;
      end
      apint_pkg::S_SAVE_VDT: cmd.op = apint_pkg::OP_SAVE_VDT;
      apint_pkg::S_ROT_INIT: cmd.op = apint_pkg::OP_ROT_INIT;
      apint_pkg::S_ROT:      cmd.op = apint_pkg::OP_ROT_STEP;
      apint_pkg::S_ROT_DONE: cmd.op = apint_pkg::OP_ROT_DONE;
      apint_pkg::S_MUL_LCS: begin
        cmd.op   = apint_pkg::OP_MUL;
        cmd.msel = apint_pkg::MS_LCS;
      end
      apint_pkg::S_DIV_INIT: cmd.op = apint_pkg::OP_DIV_INIT;
      apint_pkg::S_DIV:      cmd.op = apint_pkg::OP_DIV_STEP;
      apint_pkg::S_DIV_DONE: cmd.op = apint_pkg::OP_DIV_DONE;
      apint_pkg::S_MUL_VRAD: begin
        cmd.op   = apint_pkg::OP_MUL;
        cmd.msel = apint_pkg::MS_VRAD;
      end
      apint_pkg::S_STR_MX: begin
        cmd.op   = apint_pkg::OP_MUL;
        cmd.msel = apint_pkg::MS_VC0;
      end
      apint_pkg::S_STR_AX:   cmd.op = apint_pkg::OP_ACC_X;
      apint_pkg::S_STR_MY: begin
        cmd.op   = apint_pkg::OP_MUL;
        cmd.msel = apint_pkg::MS_VS0;
      end
      apint_pkg::S_STR_AY:   cmd.op = apint_pkg::OP_ACC_Y;
      apint_pkg::S_ARC_MX: begin
        cmd.op   = apint_pkg::OP_MUL;
        cmd.msel = apint_pkg::MS_RDS;
      end
      apint_pkg::S_ARC_AX: begin
        cmd.op  = apint_pkg::OP_ACC_X;
        cmd.arc = 1'b1;
      end
      apint_pkg::S_ARC_MY: begin
        cmd.op   = apint_pkg::OP_MUL;
        cmd.msel = apint_pkg::MS_RDC;
      end
      apint_pkg::S_ARC_AY: begin
        cmd.op  = apint_pkg::OP_ACC_Y;
        cmd.arc = 1'b1;
      end
      apint_pkg::S_YAW:      cmd.op = apint_pkg::OP_YAW;
      apint_pkg::S_OUT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = apint_pkg::OP_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/apint_dp.sv
module apint_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [31:0]         in_data,
  input  apint_pkg::cmd_t     cmd,
  output apint_pkg::stat_t    stat,
  output logic [95:0]         out_data
);

  logic        [15:0] wb_r, ts_r;
  logic signed [15:0] v_r, w_r;
  logic signed [65:0] prod_r;
  logic signed [31:0] vdt_r;
  logic signed [35:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic               neg_r;
  logic        [15:0] steer_r;
  logic signed [31:0] c0_r, s0_r, cs_r, sn_r, c1_r, s1_r;
  logic        [57:0] dq_r;
  logic        [32:0] rem_r;
  logic        [31:0] dd_r;
  logic               qneg_r;
  logic signed [31:0] r_r;
  logic        [31:0] n32_r;
  logic signed [31:0] x_r, y_r;
  logic        [15:0] yaw_r;
  logic        [95:0] out_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [35:0] vx0, vy0, cx_sh, cy_sh, rx, ry;
  logic        [31:0] tab, ang, ang_f, steer_sum, yaw_sum;
  logic               ang_neg;
  logic signed [65:0] num;
  logic        [65:0] num_mag;
  logic signed [32:0] den;
  logic        [32:0] den_mag;
  logic        [32:0] rem_sh, rem_sub;
  logic signed [58:0] qs;
  logic signed [59:0] d_sum;
  logic signed [65:0] rs_p;
  logic signed [35:0] rs36, acc_x, acc_y;

  function automatic logic signed [31:0] sat32_f(input logic signed [59:0] v);
    logic signed [31:0] s;
    if (v > 60'sd2147483647) begin
      s = 32'sh7FFFFFFF;
    end else if (v < -60'sd2147483648) begin
      s = 32'sh80000000;
    end else begin
      s = v[31:0];
    end
    return s;
  endfunction

  function automatic logic [15:0] yaw_sum_n(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h00008000;
    return t[31:16];
  endfunction

  always_comb begin
    case (cmd.msel)
      apint_pkg::MS_WL: begin
        mul_a = 33'(w_r);
        mul_b = {17'd0, wb_r};
      end
      apint_pkg::MS_VDT: begin
        mul_a = 33'(v_r);
        mul_b = {17'd0, ts_r};
      end
      apint_pkg::MS_VC0: begin
        mul_a = 33'(vdt_r);
        mul_b = 33'(c0_r);
      end
      apint_pkg::MS_VS0: begin
        mul_a = 33'(vdt_r);
        mul_b = 33'(s0_r);
      end
      apint_pkg::MS_LCS: begin
        mul_a = {17'd0, wb_r};
        mul_b = 33'(cs_r);
      end
      apint_pkg::MS_VRAD: begin
        mul_a = 33'(vdt_r);
        mul_b = apint_pkg::RAD_TO_ANG;
      end
      apint_pkg::MS_RDS: begin
        mul_a = 33'(r_r);
        mul_b = 33'(s1_r) - 33'(s0_r);
      end
      default: begin
        mul_a = 33'(r_r);
        mul_b = 33'(c0_r) - 33'(c1_r);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign vx0   = 36'(v_r) <<< 12;
  assign vy0   = prod_r[35:0];
  assign cx_sh = cx_r >>> cmd.iter;
  assign cy_sh = cy_r >>> cmd.iter;
  assign tab   = apint_pkg::atan_f(cmd.iter[4:0]);

  always_comb begin
    case (cmd.src)
      apint_pkg::SRC_YAW:   ang = {yaw_r, 16'h0};
      apint_pkg::SRC_STEER: ang = {steer_r, 16'h0};
      default:              ang = n32_r;
    endcase
  end
  assign yaw_sum = ang + 32'h40000000;
  assign ang_neg = yaw_sum[31];
  assign ang_f   = ang_neg ? ang + 32'h80000000 : ang;

  assign rx = neg_r ? -cx_r : cx_r;
  assign ry = neg_r ? -cy_r : cy_r;

  assign steer_sum = cz_r[31:0] + 32'h00008000;

  assign num     = (cmd.src == apint_pkg::SRC_STEER) ? (prod_r <<< 4) : prod_r;
  assign num_mag = num[65] ? 66'(-num) : 66'(num);
  assign den     = (cmd.src == apint_pkg::SRC_STEER) ? 33'(sn_r) : 33'(r_r);
  assign den_mag = den[32] ? 33'(-den) : 33'(den);
  assign rem_sh  = {rem_r[31:0], dq_r[57]};
  assign rem_sub = rem_sh - {1'b0, dd_r};
  assign qs      = qneg_r ? -{1'b0, dq_r} : {1'b0, dq_r};
  assign d_sum   = (60'(qs) + 60'sd128) >>> 8;

  assign rs_p  = cmd.arc ? ((prod_r + (66'sd1 <<< 29)) >>> 30)
                         : ((prod_r + (66'sd1 <<< 41)) >>> 42);
  assign rs36  = rs_p[35:0];
  assign acc_x = 36'(x_r) + rs36;
  assign acc_y = 36'(y_r) + rs36;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r    <= apint_pkg::WB_RESET;
      ts_r    <= apint_pkg::TS_RESET;
      x_r     <= '0;
      y_r     <= '0;
      yaw_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          apint_pkg::CFG_WHEEL_BASE: wb_r <= cfg_data;
          apint_pkg::CFG_TIME_STEP:  ts_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        apint_pkg::OP_ACC_X: x_r   <= sat32_f(60'(acc_x));
        apint_pkg::OP_ACC_Y: y_r   <= sat32_f(60'(acc_y));
        apint_pkg::OP_YAW:   yaw_r <= yaw_sum_n(n32_r);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      apint_pkg::OP_LOAD: begin
        v_r <= in_data[15:0];
        w_r <= in_data[31:16];
      end
      apint_pkg::OP_MUL:      prod_r <= mul_p;
      apint_pkg::OP_SAVE_VDT: vdt_r  <= prod_r[31:0];
      apint_pkg::OP_VEC_INIT: begin
        cx_r <= v_r[15] ? -vx0 : vx0;
        cy_r <= v_r[15] ? -vy0 : vy0;
        cz_r <= v_r[15] ? 34'sh080000000 : 34'sd0;
      end
      apint_pkg::OP_VEC_STEP: begin
        if (!cy_r[35] && cy_r != 36'sd0) begin
          cx_r <= cx_r + cy_sh;
          cy_r <= cy_r - cx_sh;
          cz_r <= cz_r + 34'(tab);
        end else if (cy_r[35]) begin
          cx_r <= cx_r - cy_sh;
          cy_r <= cy_r + cx_sh;
          cz_r <= cz_r - 34'(tab);
        end
      end
      apint_pkg::OP_VEC_DONE: steer_r <= steer_sum[31:16];
      apint_pkg::OP_ROT_INIT: begin
        cx_r  <= apint_pkg::KGAIN;
        cy_r  <= '0;
        cz_r  <= 34'(signed'(ang_f));
        neg_r <= ang_neg;
      end
      apint_pkg::OP_ROT_STEP: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - cy_sh;
          cy_r <= cy_r + cx_sh;
          cz_r <= cz_r - 34'(tab);
        end else begin
          cx_r <= cx_r + cy_sh;
          cy_r <= cy_r - cx_sh;
          cz_r <= cz_r + 34'(tab);
        end
      end
      apint_pkg::OP_ROT_DONE: begin
        case (cmd.src)
          apint_pkg::SRC_YAW: begin
            c0_r <= rx[31:0];
            s0_r <= ry[31:0];
          end
          apint_pkg::SRC_STEER: begin
            cs_r <= rx[31:0];
            sn_r <= ry[31:0];
          end
          default: begin
            c1_r <= rx[31:0];
            s1_r <= ry[31:0];
          end
        endcase
      end
      apint_pkg::OP_DIV_INIT: begin
        dq_r   <= num_mag[57:0];
        rem_r  <= '0;
        dd_r   <= den_mag[31:0];
        qneg_r <= num[65] ^ den[32];
      end
      apint_pkg::OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, dd_r}) begin
          rem_r <= rem_sub;
          dq_r  <= {dq_r[56:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dq_r  <= {dq_r[56:0], 1'b0};
        end
      end
      apint_pkg::OP_DIV_DONE: begin
        if (cmd.src == apint_pkg::SRC_STEER) begin
          r_r <= sat32_f(60'(qs));
        end else begin
          n32_r <= {yaw_r, 16'h0} + d_sum[31:0];
        end
      end
      default: ;
    endcase
    if (cmd.emit) begin
      out_r <= {steer_r, yaw_r, y_r, x_r};
    end
  end

  assign stat.straight = steer_r == 16'h0000 || steer_r == 16'h8000;
  assign stat.sn_zero  = sn_r == 32'sd0;
  assign stat.r_zero   = r_r == 32'sd0;
  assign out_data      = out_r;

endmodule
